// ----- src/cpt_pkg.sv -----
`default_nettype none

package cpt_pkg;

  // Width of the skip step count field.
  localparam int STEPS_W = 8;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_CLOSEST = 2'd2,
    KIND_SKIP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted input item
    logic scan_start;  // begin a newest-to-oldest distance scan
    logic commit;      // load the result registers and update the table
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;       // kind of the captured item
    logic  empty;      // table holds no entries
    logic  scan_busy;  // reads or distance stages still in flight
  } stat_t;

endpackage

`default_nettype wire

// ----- src/cpt_ram.sv -----
`default_nettype none

module cpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/cpt_datapath.sv -----
`default_nettype none

module cpt_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cpt_pkg::cmd_t                  cmd,
  output cpt_pkg::stat_t                      stat,
  input  wire logic [1:0]                     kind,
  input  wire logic signed [COORD_BITS-1:0]   x_coord,
  input  wire logic signed [COORD_BITS-1:0]   y_coord,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] start_slot,
  input  wire logic [cpt_pkg::STEPS_W-1:0]    steps,
  output logic      [$clog2(TABLE_DEPTH)-1:0] slot,
  output logic      [2*COORD_BITS:0]          best_dist_sq,
  output logic      [1:0]                     status
);

  localparam int SlotW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int C     = COORD_BITS;
  localparam int DistW = 2 * COORD_BITS + 1;
  localparam int SkW   = (SlotW > cpt_pkg::STEPS_W) ? SlotW : cpt_pkg::STEPS_W;

  // Captured item.
  cpt_pkg::kind_t             kind_reg;
  logic signed [C-1:0]        qx;
  logic signed [C-1:0]        qy;
  logic [SlotW-1:0]           start_reg;
  logic [cpt_pkg::STEPS_W-1:0] steps_reg;

  logic [CntW-1:0] count;
  logic            full;
  logic            empty;

  // Scan pipeline.
  logic             issue_active;
  logic [SlotW-1:0] rd_idx;
  logic             v1, v2, v3;
  logic [SlotW-1:0] i1, i2, i3;
  logic [2*C-1:0]   rd_data;
  logic [C-1:0]     dx, dy;
  logic [2*C-1:0]   sqx, sqy;
  logic [DistW-1:0] sum;
  logic             best_valid;
  logic [SlotW-1:0] best_idx;
  logic [DistW-1:0] best_d;

  logic signed [C:0] ddx, ddy;
  logic [C:0]        adx, ady;

  // Skip destination.
  logic [SlotW-1:0] skip_pos;
  logic [SkW-1:0]   pos_ext;
  logic [SkW-1:0]   steps_ext;
  logic [SkW-1:0]   skip_diff;
  logic [SlotW-1:0] skip_dest;

  cpt_pkg::status_t status_reg;

  assign full  = (count == CntW'(TABLE_DEPTH));
  assign empty = (count == '0);

  assign stat.kind      = kind_reg;
  assign stat.empty     = empty;
  assign stat.scan_busy = issue_active | v1 | v2 | v3;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_reg  <= cpt_pkg::kind_t'(kind);
      qx        <= x_coord;
      qy        <= y_coord;
      start_reg <= start_slot;
      steps_reg <= steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (kind_reg == cpt_pkg::KIND_ADD && !full) begin
        count <= count + 1'b1;
      end else if (kind_reg == cpt_pkg::KIND_CLEAR) begin
        count <= '0;
      end
    end
  end

  cpt_ram #(
    .WIDTH(2 * C),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && kind_reg == cpt_pkg::KIND_ADD && !full),
    .wr_addr (count[SlotW-1:0]),
    .wr_data ({qx, qy}),
    .rd_en   (issue_active),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // Read issue walks from the newest slot down to slot 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      best_valid   <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issue_active <= 1'b1;
      end else if (issue_active && rd_idx == '0) begin
        issue_active <= 1'b0;
      end
      v1 <= issue_active;
      v2 <= v1;
      v3 <= v2;
      if (cmd.scan_start) begin
        best_valid <= 1'b0;
      end else if (v3) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_idx <= SlotW'(count - 1'b1);
    end else if (issue_active && rd_idx != '0) begin
      rd_idx <= rd_idx - 1'b1;
    end
  end

  always_comb begin
    ddx = $signed({rd_data[2*C-1], rd_data[2*C-1:C]}) - $signed({qx[C-1], qx});
    ddy = $signed({rd_data[C-1], rd_data[C-1:0]}) - $signed({qy[C-1], qy});
    adx = ddx[C] ? $unsigned(-ddx) : $unsigned(ddx);
    ady = ddy[C] ? $unsigned(-ddy) : $unsigned(ddy);
  end

  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    i1  <= rd_idx;
    i2  <= i1;
    i3  <= i2;
    dx  <= adx[C-1:0];
    dy  <= ady[C-1:0];
    sqx <= (2*C)'(dx) * (2*C)'(dx);
    sqy <= (2*C)'(dy) * (2*C)'(dy);
    // Strictly smaller wins, so on a tie the newer entry stays.
    if (v3 && (!best_valid || sum < best_d)) begin
      best_d   <= sum;
      best_idx <= i3;
    end
  end

  always_comb begin
    if (CntW'(start_reg) >= count) begin
      skip_pos = SlotW'(count - 1'b1);
    end else begin
      skip_pos = start_reg;
    end
    pos_ext   = SkW'(skip_pos);
    steps_ext = SkW'(steps_reg);
    skip_diff = pos_ext - steps_ext;
    skip_dest = (steps_ext >= pos_ext) ? '0 : skip_diff[SlotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot         <= '0;
      best_dist_sq <= '0;
      status_reg   <= cpt_pkg::STATUS_OK;
      case (kind_reg)
        cpt_pkg::KIND_ADD: begin
          if (full) begin
            status_reg <= cpt_pkg::STATUS_FULL;
          end
        end
        cpt_pkg::KIND_CLEAR: begin
        end
        cpt_pkg::KIND_CLOSEST: begin
          if (empty) begin
            status_reg <= cpt_pkg::STATUS_EMPTY;
          end else begin
            slot         <= best_idx;
            best_dist_sq <= best_d;
          end
        end
        cpt_pkg::KIND_SKIP: begin
          if (empty) begin
            status_reg <= cpt_pkg::STATUS_EMPTY;
          end else begin
            slot <= skip_dest;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status = status_reg;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_issue_nonempty: assert property (@(posedge clk) disable iff (rst)
    issue_active |-> !empty)
    else $error("scan reading from an empty table");

  a_best_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && kind_reg == cpt_pkg::KIND_CLOSEST && !empty) |-> best_valid)
    else $error("closest result committed before any distance was compared");
`endif

endmodule

`default_nettype wire

// ----- src/cpt_ctrl.sv -----
`default_nettype none

module cpt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire cpt_pkg::stat_t stat,
  output cpt_pkg::cmd_t       cmd
);

  cpt_pkg::state_t state;
  cpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cpt_pkg::ST_EXEC;
        end
      end
      cpt_pkg::ST_EXEC: begin
        if (stat.kind == cpt_pkg::KIND_CLOSEST && !stat.empty) begin
          state_next = cpt_pkg::ST_SCAN;
        end else begin
          state_next = cpt_pkg::ST_FINISH;
        end
      end
      cpt_pkg::ST_SCAN: begin
        if (!stat.scan_busy) begin
          state_next = cpt_pkg::ST_FINISH;
        end
      end
      cpt_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = cpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.commit     = 1'b0;
    case (state)
      cpt_pkg::ST_IDLE: begin
        // No transfer is taken while reset is held.
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      cpt_pkg::ST_EXEC: begin
        cmd.scan_start = (stat.kind == cpt_pkg::KIND_CLOSEST) && !stat.empty;
      end
      cpt_pkg::ST_SCAN: begin
      end
      cpt_pkg::ST_FINISH: begin
        cmd.commit = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.scan_busy |-> state == cpt_pkg::ST_SCAN)
    else $error("scan pipeline active outside the scan state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cpt_pkg::ST_FINISH)
    else $error("result appeared without a commit");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == cpt_pkg::ST_EXEC && !in_ready)
    else $error("second item accepted while one is in progress");
`endif

endmodule

`default_nettype wire

// ----- src/closest_position_table_unit.sv -----
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------
// input    in_valid / in_ready  kind, x_coord, y_coord, start_slot, steps
// output   out_valid/out_ready  slot, best_dist_sq, status
//
// One item is in progress at a time; in_ready is high only while the block is idle.
// Add, clear and skip pass from the input transfer through execute and finish states
// to the result. A closest query on a non-empty table adds a distance scan between,
// paced by the table memory's single read port, which delivers one entry per cycle.
// A result waiting in the output register does not block the next input transfer;
// only the following result waits for it. Reset empties the table at once.

module closest_position_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     kind,
  input  wire logic signed [COORD_BITS-1:0]   x_coord,
  input  wire logic signed [COORD_BITS-1:0]   y_coord,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] start_slot,
  input  wire logic [cpt_pkg::STEPS_W-1:0]    steps,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [$clog2(TABLE_DEPTH)-1:0] slot,
  output logic      [2*COORD_BITS:0]          best_dist_sq,
  output logic      [1:0]                     status
);

  // The controller sequences each item through capture, execute, an optional
  // distance scan, and a commit that writes the result register and updates
  // the table. The datapath holds the table memory, the entry count, the
  // four-stage distance pipeline and the running best.
  cpt_pkg::cmd_t  cmd;
  cpt_pkg::stat_t stat;

  cpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .start_slot   (start_slot),
    .steps        (steps),
    .slot         (slot),
    .best_dist_sq (best_dist_sq),
    .status       (status)
  );

endmodule

`default_nettype wire
